FILE: design/fcst_pkg.sv
// Package for the fixed capacity set table: command and status codes,
// the token that travels down the cell chain and the cell write request.
// No dependencies.
package fcst_pkg;

    // Widest slot index over the supported capacity range (up to 1024 slots)
    localparam int SLOT_W_MAX = 10;
    localparam int KEY_W      = 32;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 7;
    localparam int OCC_W      = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_ALT_Q  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Search token: one per item, moves one cell per cycle
    typedef struct packed {
        logic                  vld;
        logic                  hit;
        logic [SLOT_W_MAX-1:0] slot;
        logic [KEY_W-1:0]      last_key;
    } t_token;

    // Write request broadcast to all cells
    typedef struct packed {
        logic                  en;
        logic [SLOT_W_MAX-1:0] slot;
        logic [KEY_W-1:0]      data;
    } t_wr;

endpackage

FILE: design/fcst_cmd_if.sv
// Command channel of the set table: valid/ready handshake with command and key.
// Depends on fcst_pkg for field widths.
interface fcst_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [fcst_pkg::CMD_W-1:0]   command;
    logic [fcst_pkg::KEY_W-1:0]   key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

FILE: design/fcst_rsp_if.sv
// Response channel of the set table: valid/ready handshake with the result fields.
// Depends on fcst_pkg for field widths.
interface fcst_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [fcst_pkg::STATUS_W-1:0]  status;
    logic                           found;
    logic [fcst_pkg::SLOT_W-1:0]    slot;
    logic [fcst_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, output status, output found, output slot,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input found, input slot,
                    input occupancy, output ready);
endinterface

FILE: design/fcst_cell.sv
// One slot of the set table: holds a key, compares it against the search key
// as the token passes, and takes broadcast writes. Depends on fcst_pkg.
module fcst_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [fcst_pkg::KEY_W-1:0]    i_qkey,
    input  logic [CW-1:0]                 i_count,
    input  fcst_pkg::t_token              i_tok,
    input  fcst_pkg::t_wr                 i_wr,
    output fcst_pkg::t_token              o_tok
);

    localparam logic [CW-1:0]                   IDX_C   = CW'(INDEX);
    localparam logic [CW-1:0]                   IDX_P1  = CW'(INDEX + 1);
    localparam logic [fcst_pkg::SLOT_W_MAX-1:0] IDX_S   = fcst_pkg::SLOT_W_MAX'(INDEX);

    logic [fcst_pkg::KEY_W-1:0] r_key;
    fcst_pkg::t_token           r_tok;
    fcst_pkg::t_token           n_tok;
    logic                       w_match;

    // Slot is live only below the fill count
    assign w_match = (IDX_C < i_count) && (r_key == i_qkey);

    // Token update: first hit wins, last live entry is picked up on the way
    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && w_match) begin
            n_tok.hit  = 1'b1;
            n_tok.slot = IDX_S;
        end
        if (IDX_P1 == i_count) begin
            n_tok.last_key = r_key;
        end
    end

    // Key storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.slot == IDX_S)) begin
            r_key <= i_wr.data;
        end
    end

    // Token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
        end
        r_tok.hit      <= n_tok.hit;
        r_tok.slot     <= n_tok.slot;
        r_tok.last_key <= n_tok.last_key;
    end

    assign o_tok = r_tok;

endmodule

FILE: design/fixed_capacity_set_table_core.sv
// Fixed capacity set table: unordered set of distinct 32-bit keys, swap remove.
// The search token walks the cell chain one slot per cycle. One item at a time:
// a new command is taken only once the last one has retired. A waiting response does
// not block the next command beat, but that command cannot retire until the
// response is taken. Sync active-low reset empties the set; keys are not cleared.
module fixed_capacity_set_table_core #(
    parameter int CAPACITY = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fcst_cmd_if.sink     i_cmd,
    fcst_rsp_if.source   o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                                 r_state;
    logic                                   r_inject;
    logic [fcst_pkg::CMD_W-1:0]             r_cmd;
    logic [fcst_pkg::KEY_W-1:0]             r_qkey;
    logic [CW-1:0]                          r_count;
    logic                                   r_hit;
    logic [fcst_pkg::SLOT_W_MAX-1:0]        r_pos;
    logic [fcst_pkg::KEY_W-1:0]             r_last;
    logic                                   r_out_vld;
    logic [fcst_pkg::STATUS_W-1:0]          r_status;
    logic                                   r_found;
    logic [fcst_pkg::SLOT_W-1:0]            r_slot;
    logic [fcst_pkg::OCC_W-1:0]             r_occ;

    logic [CW-1:0]                          n_count;
    logic [fcst_pkg::STATUS_W-1:0]          n_status;
    logic [fcst_pkg::SLOT_W_MAX-1:0]        n_slot;
    logic                                   w_accept;
    logic                                   w_retire;
    fcst_pkg::t_wr                          w_wr;
    fcst_pkg::t_token                       w_tok [CAPACITY+1];

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && (r_state == S_IDLE);
    assign w_retire    = (r_state == S_DONE) && (!r_out_vld || o_rsp.ready);

    // Token entering the first cell
    assign w_tok[0] = '{vld: r_inject, hit: 1'b0, slot: '0, last_key: '0};

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        fcst_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_qkey  (r_qkey),
            .i_count (r_count),
            .i_tok   (w_tok[g]),
            .i_wr    (w_wr),
            .o_tok   (w_tok[g+1])
        );
    end

    // Result and update decision once the search is complete
    always_comb begin
        n_count  = r_count;
        n_status = fcst_pkg::ST_DONE;
        n_slot   = r_hit ? r_pos : '0;
        w_wr     = '{en: 1'b0, slot: '0, data: r_qkey};
        case (fcst_pkg::t_cmd'(r_cmd))
            fcst_pkg::CMD_INSERT: begin
                if (r_hit) begin
                    n_status = fcst_pkg::ST_PRESENT;
                end else if (r_count >= CAP_C) begin
                    n_status = fcst_pkg::ST_FULL;
                    n_slot   = '0;
                end else begin
                    n_slot  = fcst_pkg::SLOT_W_MAX'(r_count);
                    n_count = r_count + CW'(1);
                    w_wr    = '{en: w_retire, slot: fcst_pkg::SLOT_W_MAX'(r_count),
                                data: r_qkey};
                end
            end
            fcst_pkg::CMD_REMOVE: begin
                if (!r_hit) begin
                    n_status = fcst_pkg::ST_ABSENT;
                    n_slot   = '0;
                end else begin
                    n_count = r_count - CW'(1);
                    w_wr    = '{en: w_retire, slot: r_pos, data: r_last};
                end
            end
            default: begin
                n_status = fcst_pkg::ST_DONE;
            end
        endcase
    end

    // Sequencer, count and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_inject  <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_inject <= w_accept;
            if (r_out_vld && o_rsp.ready && !w_retire) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_tok[CAPACITY].vld) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_retire) begin
                        r_state   <= S_IDLE;
                        r_count   <= n_count;
                        r_out_vld <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        // Payload registers
        if (w_accept) begin
            r_cmd  <= i_cmd.command;
            r_qkey <= i_cmd.key;
        end
        if (w_tok[CAPACITY].vld) begin
            r_hit  <= w_tok[CAPACITY].hit;
            r_pos  <= w_tok[CAPACITY].slot;
            r_last <= w_tok[CAPACITY].last_key;
        end
        if (w_retire) begin
            r_status <= n_status;
            r_found  <= r_hit;
            r_slot   <= n_slot[fcst_pkg::SLOT_W-1:0];
            r_occ    <= fcst_pkg::OCC_W'(n_count);
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.status    = r_status;
    assign o_rsp.found     = r_found;
    assign o_rsp.slot      = r_slot;
    assign o_rsp.occupancy = r_occ;

endmodule
